>>> rtl/core/vips_pkg.sv
// shared types and codes for the virtual irq pending selector
// request codes, source kinds and configuration register indexes
// no dependencies
package vips_pkg;

    typedef logic [2:0] req_t;
    typedef logic [2:0] kind_t;

    localparam req_t REQ_HW_RAISE  = 3'd0;
    localparam req_t REQ_EXT_RAISE = 3'd1;
    localparam req_t REQ_TRAP      = 3'd2;
    localparam req_t REQ_SW_TRAP   = 3'd3;
    localparam req_t REQ_HW_MASK   = 3'd4;
    localparam req_t REQ_EXT_MASK  = 3'd5;
    localparam req_t REQ_ENABLE    = 3'd6;
    localparam req_t REQ_DISPATCH  = 3'd7;

    localparam kind_t KIND_NONE     = 3'd0;
    localparam kind_t KIND_SW_TRAP  = 3'd1;
    localparam kind_t KIND_TRAP     = 3'd2;
    localparam kind_t KIND_EXT_TRAP = 3'd3;
    localparam kind_t KIND_HW_IRQ   = 3'd4;
    localparam kind_t KIND_EXT_IRQ  = 3'd5;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int WORD_W     = 32;
    localparam int BIT_IDX_W  = 5;
    localparam int SRC_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_LOWEST_FIRST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_TRAP_BITS         = 1'd1;

endpackage

>>> rtl/core/vips_pick.sv
// bit priority encoder: lowest or highest set bit of a word
// depends on nothing; instantiated by virtual_irq_pending_selector
module vips_pick #(
    parameter int WIDTH = 32,
    parameter int IDX_W = 5
) (
    input  logic [WIDTH-1:0] word,
    input  logic             lowest_first,
    output logic [IDX_W-1:0] idx
);

    logic [IDX_W-1:0] low_idx;
    logic [IDX_W-1:0] high_idx;

    // last hit wins, so scan direction sets which end has priority
    always_comb
    begin
        low_idx  = '0;
        high_idx = '0;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                low_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < WIDTH; i++)
        begin
            if (word[i])
            begin
                high_idx = IDX_W'(i);
            end
        end
    end

    assign idx = lowest_first ? low_idx : high_idx;

endmodule

>>> rtl/core/virtual_irq_pending_selector.sv
// virtual interrupt pending and dispatch selector for one guest
// holds pending and mask words, trap flags and the enable flag
// depends on vips_pkg and vips_pick
//
// usage: every input transaction carries one request (raise, trap post,
// mask write, enable write or dispatch) and gives exactly one output
// transaction. event requests return taken 0, kind none, index 0.
// dispatch picks one source: software trap, pending trap, extended trap,
// hardware irq, extended irq, and clears or masks what it selected.
// the result appears in the output register in the cycle after
// acceptance. throughput: one transaction per cycle unless the receiver
// stalls; the state update and selection are one level of priority
// encoding between registers. when the receiver stalls, the output
// register holds its result and in_ready drops until it is taken; a new
// request is accepted in the same cycle the held result leaves.
// reset clears all pending, mask and flag state and the config registers.
// configuration writes on cfg_we are registered, no handshake.
module virtual_irq_pending_selector #(
    parameter int IRQ_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [vips_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vips_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  vips_pkg::req_t                      req_type,
    input  logic [vips_pkg::BIT_IDX_W-1:0]      bit_index,
    input  logic [vips_pkg::WORD_W-1:0]         word_value,
    input  logic                                guest_present,
    input  logic                                hypervisor_context,
    input  logic [7:0]                          trap_number,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                taken,
    output vips_pkg::kind_t                     source_kind,
    output logic [vips_pkg::SRC_IDX_W-1:0]      source_index
);

    localparam int IDX_W = (IRQ_BITS > 1) ? $clog2(IRQ_BITS) : 1;

    // configuration
    logic                                priority_lowest_first_reg;
    logic [vips_pkg::CFG_DATA_W-1:0]     ext_trap_bits_reg;

    // guest state
    logic [IRQ_BITS-1:0] hw_pending_reg,  hw_pending_next;
    logic [IRQ_BITS-1:0] hw_masked_reg,   hw_masked_next;
    logic [IRQ_BITS-1:0] ext_pending_reg, ext_pending_next;
    logic [IRQ_BITS-1:0] ext_masked_reg,  ext_masked_next;
    logic                irqs_enabled_reg, irqs_enabled_next;
    logic                trap_waiting_reg, trap_waiting_next;
    logic                soft_valid_reg,   soft_valid_next;
    logic [7:0]          soft_vector_reg,  soft_vector_next;

    // output register
    logic                               out_valid_reg;
    logic                               taken_reg,  taken_next;
    vips_pkg::kind_t                    kind_reg,   kind_next;
    logic [vips_pkg::SRC_IDX_W-1:0]     index_reg,  index_next;

    logic                in_accept;
    logic [IRQ_BITS-1:0] word_fit;
    logic [IRQ_BITS-1:0] trap_fit;
    logic [IRQ_BITS-1:0] raise_bit;
    logic [IRQ_BITS-1:0] ext_trap_word;
    logic [IRQ_BITS-1:0] hw_word;
    logic [IRQ_BITS-1:0] ext_word;
    logic [IDX_W-1:0]    ext_trap_idx;
    logic [IDX_W-1:0]    hw_idx;
    logic [IDX_W-1:0]    ext_idx;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // fit 32-bit words to the irq width: drop high bits or zero extend
    generate
        if (IRQ_BITS <= vips_pkg::WORD_W)
        begin : g_narrow
            assign word_fit = word_value[IRQ_BITS-1:0];
            assign trap_fit = ext_trap_bits_reg[IRQ_BITS-1:0];
        end
        else
        begin : g_wide
            assign word_fit = IRQ_BITS'(word_value);
            assign trap_fit = IRQ_BITS'(ext_trap_bits_reg);
        end
    endgenerate

    // a bit index at or beyond the width shifts out to zero
    assign raise_bit = IRQ_BITS'(1) << bit_index;

    assign ext_trap_word = ext_pending_reg & trap_fit;
    assign hw_word       = hw_pending_reg & ~hw_masked_reg;
    assign ext_word      = ext_pending_reg & ~ext_masked_reg;

    vips_pick #(.WIDTH(IRQ_BITS), .IDX_W(IDX_W)) u_pick_ext_trap (
        .word         (ext_trap_word),
        .lowest_first (priority_lowest_first_reg),
        .idx          (ext_trap_idx)
    );

    vips_pick #(.WIDTH(IRQ_BITS), .IDX_W(IDX_W)) u_pick_hw (
        .word         (hw_word),
        .lowest_first (priority_lowest_first_reg),
        .idx          (hw_idx)
    );

    vips_pick #(.WIDTH(IRQ_BITS), .IDX_W(IDX_W)) u_pick_ext (
        .word         (ext_word),
        .lowest_first (priority_lowest_first_reg),
        .idx          (ext_idx)
    );

    always_comb
    begin
        hw_pending_next   = hw_pending_reg;
        hw_masked_next    = hw_masked_reg;
        ext_pending_next  = ext_pending_reg;
        ext_masked_next   = ext_masked_reg;
        irqs_enabled_next = irqs_enabled_reg;
        trap_waiting_next = trap_waiting_reg;
        soft_valid_next   = soft_valid_reg;
        soft_vector_next  = soft_vector_reg;
        taken_next        = 1'b0;
        kind_next         = vips_pkg::KIND_NONE;
        index_next        = '0;

        unique case (req_type)
            vips_pkg::REQ_HW_RAISE:
            begin
                hw_pending_next = hw_pending_reg | raise_bit;
            end
            vips_pkg::REQ_EXT_RAISE:
            begin
                ext_pending_next = ext_pending_reg | raise_bit;
            end
            vips_pkg::REQ_TRAP:
            begin
                trap_waiting_next = 1'b1;
            end
            vips_pkg::REQ_SW_TRAP:
            begin
                soft_valid_next  = 1'b1;
                soft_vector_next = word_value[7:0];
            end
            vips_pkg::REQ_HW_MASK:
            begin
                hw_masked_next = word_fit;
            end
            vips_pkg::REQ_EXT_MASK:
            begin
                ext_masked_next = word_fit;
            end
            vips_pkg::REQ_ENABLE:
            begin
                irqs_enabled_next = word_value[0];
            end
            vips_pkg::REQ_DISPATCH:
            begin
                if (guest_present && !hypervisor_context)
                begin
                    if (soft_valid_reg)
                    begin
                        soft_valid_next  = 1'b0;
                        soft_vector_next = '0;
                        taken_next       = 1'b1;
                        kind_next        = vips_pkg::KIND_SW_TRAP;
                        index_next       = soft_vector_reg;
                    end
                    else if (trap_waiting_reg)
                    begin
                        trap_waiting_next = 1'b0;
                        irqs_enabled_next = 1'b0;
                        taken_next        = 1'b1;
                        kind_next         = vips_pkg::KIND_TRAP;
                        index_next        = trap_number;
                    end
                    else if (|ext_trap_word)
                    begin
                        // extended traps bypass both mask and enable flag
                        ext_pending_next  = ext_pending_reg & ~(IRQ_BITS'(1) << ext_trap_idx);
                        irqs_enabled_next = 1'b0;
                        taken_next        = 1'b1;
                        kind_next         = vips_pkg::KIND_EXT_TRAP;
                        index_next        = vips_pkg::SRC_IDX_W'(ext_trap_idx);
                    end
                    else if (irqs_enabled_reg && |hw_word)
                    begin
                        hw_pending_next   = hw_pending_reg & ~(IRQ_BITS'(1) << hw_idx);
                        hw_masked_next    = hw_masked_reg | (IRQ_BITS'(1) << hw_idx);
                        irqs_enabled_next = 1'b0;
                        taken_next        = 1'b1;
                        kind_next         = vips_pkg::KIND_HW_IRQ;
                        index_next        = vips_pkg::SRC_IDX_W'(hw_idx);
                    end
                    else if (irqs_enabled_reg && |ext_word)
                    begin
                        ext_pending_next  = ext_pending_reg & ~(IRQ_BITS'(1) << ext_idx);
                        ext_masked_next   = ext_masked_reg | (IRQ_BITS'(1) << ext_idx);
                        irqs_enabled_next = 1'b0;
                        taken_next        = 1'b1;
                        kind_next         = vips_pkg::KIND_EXT_IRQ;
                        index_next        = vips_pkg::SRC_IDX_W'(ext_idx);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            priority_lowest_first_reg <= 1'b0;
            ext_trap_bits_reg         <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vips_pkg::CFG_PRIORITY_LOWEST_FIRST:
                begin
                    priority_lowest_first_reg <= cfg_data[0];
                end
                vips_pkg::CFG_EXT_TRAP_BITS:
                begin
                    ext_trap_bits_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_pending_reg   <= '0;
            hw_masked_reg    <= '0;
            ext_pending_reg  <= '0;
            ext_masked_reg   <= '0;
            irqs_enabled_reg <= 1'b0;
            trap_waiting_reg <= 1'b0;
            soft_valid_reg   <= 1'b0;
            soft_vector_reg  <= '0;
        end
        else if (in_accept)
        begin
            hw_pending_reg   <= hw_pending_next;
            hw_masked_reg    <= hw_masked_next;
            ext_pending_reg  <= ext_pending_next;
            ext_masked_reg   <= ext_masked_next;
            irqs_enabled_reg <= irqs_enabled_next;
            trap_waiting_reg <= trap_waiting_next;
            soft_valid_reg   <= soft_valid_next;
            soft_vector_reg  <= soft_vector_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // result payload, loaded with each accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            taken_reg <= taken_next;
            kind_reg  <= kind_next;
            index_reg <= index_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign taken        = taken_reg;
    assign source_kind  = kind_reg;
    assign source_index = index_reg;

endmodule
